FILE: rtl/core/srpg_pkg.sv
// Shared types, widths, register indexes and constants of the stepper ramp pulse generator.
package srpg_pkg;

  // Field and register widths.
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned MOVE_W     = 16;
  localparam int unsigned RAMP_W     = 10;
  localparam int unsigned SPR_W      = 16;
  localparam int unsigned MINP_W     = 10;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned TIME_W     = 26;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned LEFT_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Serial multiply/divide unit: operand widths and quotient lengths.
  localparam int unsigned OPA_W       = 33;
  localparam int unsigned OPB_W       = 26;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned SHORT_QBITS = 10;
  localparam int unsigned LONG_QBITS  = 26;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_MOVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_REV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY        = 3'd5;

  // Register reset values.
  localparam logic [SPEED_W-1:0] MOVE_SPEED_RST = 10'd60;
  localparam logic [MOVE_W-1:0]  STEPS_MOVE_RST = 16'd1000;
  localparam logic [RAMP_W-1:0]  RAMP_STEPS_RST = 10'd100;
  localparam logic [SPR_W-1:0]   STEPS_REV_RST  = 16'd800;
  localparam logic [MINP_W-1:0]  MIN_PULSE_RST  = 10'd10;
  localparam logic [DUTY_W-1:0]  DUTY_RST       = 7'd50;

  // Arithmetic constants.
  localparam logic [TIME_W-1:0] PERIOD_NUM_US = 26'd60000000;
  localparam logic [TIME_W-1:0] IDLE_WAIT_US  = 26'd1000;
  localparam logic [DUTY_W-1:0] DUTY_FULL     = 7'd100;

  typedef struct packed {
    logic start_move;
    logic want_up;
  } srpg_in_t;

  typedef struct packed {
    logic                dir_level;
    logic                dir_switched;
    logic                pulse_issued;
    logic [TIME_W-1:0]   high_time_us;
    logic [TIME_W-1:0]   low_time_us;
    logic [SPEED_W-1:0]  speed_now_rpm;
    logic [COUNT_W-1:0]  steps_since_reversal;
  } srpg_out_t;

  // Command to the serial arithmetic unit.
  typedef struct packed {
    logic start;
    logic is_div;
    logic short_div;
  } srpg_req_t;

  // Status from the serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } srpg_rsp_t;

  typedef enum logic [1:0] {
    UNIT_IDLE,
    UNIT_MUL,
    UNIT_DIV
  } srpg_unit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAMP,
    ST_RAMP_MUL,
    ST_RAMP_DIV,
    ST_SPM,
    ST_SPM_WAIT,
    ST_PER_WAIT,
    ST_PULSE,
    ST_DUTY_MUL,
    ST_DUTY_DIV,
    ST_OUT
  } srpg_state_e;

endpackage

FILE: rtl/core/srpg_if.sv
// Valid/ready channel interfaces for the slot items and the result items.
interface srpg_in_if;
  import srpg_pkg::*;

  logic     valid;
  logic     ready;
  srpg_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srpg_out_if;
  import srpg_pkg::*;

  logic      valid;
  logic      ready;
  srpg_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/stepper_ramp_pulse_generator_core.sv
// Stepper ramp pulse generator: one slot item in, one pulse timing item out.
// Each slot item resolves direction and move countdown in the cycle it is taken, then steps
// the linear speed ramp, works out the step period from the speed and splits it into high
// and low time, all on one shared serial multiply/divide unit that handles one multiplier
// bit or one quotient bit per cycle. The ramp quotient has 10 bits, the period and the high
// time 26 bits each; each multiply stops once its multiplier (speed, ramp index or duty) has
// no significant bits left, and every operation hands its result back through a registered
// done flag. An item with no speed and no ramp step skips the unit. The next slot item is
// taken once the previous result sits in the output register, even if it is not yet taken.
// The user must write registers through the plain write port only while no item is in
// flight; the block itself does not enforce this.
module stepper_ramp_pulse_generator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  srpg_in_if.sink                         in_chan_i,
  srpg_out_if.source                      out_chan_o
);
  import srpg_pkg::*;

  // Configuration registers.
  logic [SPEED_W-1:0] move_speed_q;
  logic [MOVE_W-1:0]  steps_move_q;
  logic [RAMP_W-1:0]  ramp_steps_q;
  logic [SPR_W-1:0]   steps_rev_q;
  logic [MINP_W-1:0]  min_pulse_q;
  logic [DUTY_W-1:0]  duty_q;

  // Slot state.
  srpg_state_e              state_q, state_d;
  logic                     applied_up_q, applied_up_d;
  logic                     move_pending_q, move_pending_d;
  logic signed [LEFT_W-1:0] move_left_q, move_left_d;
  logic [SPEED_W-1:0]       ramp_target_q, ramp_target_d;
  logic [SPEED_W-1:0]       ramp_origin_q, ramp_origin_d;
  logic [INDEX_W-1:0]       ramp_index_q, ramp_index_d;
  logic [SPEED_W-1:0]       speed_q, speed_d;
  logic [COUNT_W-1:0]       pulse_count_q, pulse_count_d;
  logic                     switched_q, switched_d;
  logic                     issued_q, issued_d;
  logic [TIME_W-1:0]        period_q, period_d;
  logic [TIME_W-1:0]        high_q, high_d;
  logic [TIME_W-1:0]        low_q, low_d;
  logic                     out_valid_q, out_valid_d;
  srpg_out_t                out_q, out_d;

  // Slot decode helpers.
  logic                     in_acc;
  logic                     pend_now;
  logic                     changing;
  logic signed [LEFT_W-1:0] left_now;
  logic [SPEED_W-1:0]       target_now;

  // Ramp and pulse helpers.
  logic               ramp_down;
  logic [SPEED_W-1:0] ramp_span;
  logic               idx_live;
  logic               idx_end;
  logic [SPEED_W:0]   ramp_part;
  logic [DUTY_W-1:0]  duty_eff;

  // Shared arithmetic unit.
  srpg_req_t        u_req;
  srpg_rsp_t        u_rsp;
  logic [OPA_W-1:0] u_opa;
  logic [OPB_W-1:0] u_opb;
  logic [OPA_W-1:0] u_res;
  logic [OPB_W-1:0] u_rem;

  srpg_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .opa_i  (u_opa),
    .opb_i  (u_opb),
    .rsp_o  (u_rsp),
    .res_o  (u_res),
    .rem_o  (u_rem)
  );

  assign in_chan_i.ready    = (state_q == ST_IDLE);
  assign in_acc             = in_chan_i.valid && in_chan_i.ready;
  assign out_chan_o.valid   = out_valid_q;
  assign out_chan_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_speed_q <= MOVE_SPEED_RST;
      steps_move_q <= STEPS_MOVE_RST;
      ramp_steps_q <= RAMP_STEPS_RST;
      steps_rev_q  <= STEPS_REV_RST;
      min_pulse_q  <= MIN_PULSE_RST;
      duty_q       <= DUTY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOVE_SPEED: move_speed_q <= cfg_data_i[SPEED_W-1:0];
        CFG_STEPS_MOVE: steps_move_q <= cfg_data_i[MOVE_W-1:0];
        CFG_RAMP_STEPS: ramp_steps_q <= cfg_data_i[RAMP_W-1:0];
        CFG_STEPS_REV:  steps_rev_q  <= cfg_data_i[SPR_W-1:0];
        CFG_MIN_PULSE:  min_pulse_q  <= cfg_data_i[MINP_W-1:0];
        CFG_DUTY:       duty_q       <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      applied_up_q   <= 1'b0;
      move_pending_q <= 1'b0;
      move_left_q    <= '0;
      ramp_target_q  <= '0;
      ramp_origin_q  <= '0;
      ramp_index_q   <= '0;
      speed_q        <= '0;
      pulse_count_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      applied_up_q   <= applied_up_d;
      move_pending_q <= move_pending_d;
      move_left_q    <= move_left_d;
      ramp_target_q  <= ramp_target_d;
      ramp_origin_q  <= ramp_origin_d;
      ramp_index_q   <= ramp_index_d;
      speed_q        <= speed_d;
      pulse_count_q  <= pulse_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    switched_q <= switched_d;
    issued_q   <= issued_d;
    period_q   <= period_d;
    high_q     <= high_d;
    low_q      <= low_d;
    out_q      <= out_d;
  end

  // Direction and move countdown of the slot being accepted.
  always_comb begin
    pend_now   = move_pending_q | in_chan_i.payload.start_move;
    changing   = (in_chan_i.payload.want_up != applied_up_q);
    left_now   = move_left_q;
    target_now = '0;
    if (!changing) begin
      if (pend_now) begin
        left_now = LEFT_W'(signed'({1'b0, steps_move_q}));
      end
      // The countdown rests at minus one once it has run out.
      if (!left_now[LEFT_W-1]) begin
        left_now = left_now - LEFT_W'(1);
      end
      if (!left_now[LEFT_W-1] && (left_now != '0)) begin
        target_now = move_speed_q;
      end
    end
  end

  assign ramp_down = ramp_target_q < ramp_origin_q;
  assign ramp_span = ramp_down ? (ramp_origin_q - ramp_target_q)
                               : (ramp_target_q - ramp_origin_q);
  assign idx_live  = ramp_index_q <= {1'b0, ramp_steps_q};
  assign idx_end   = (ramp_index_q == {1'b0, ramp_steps_q}) || (ramp_steps_q == '0);
  // A falling ramp rounds its step towards the target.
  assign ramp_part = {1'b0, u_res[SPEED_W-1:0]}
                   + (SPEED_W+1)'(ramp_down && (u_rem != '0));
  assign duty_eff  = (duty_q > DUTY_FULL) ? DUTY_FULL : duty_q;

  always_comb begin
    state_d        = state_q;
    applied_up_d   = applied_up_q;
    move_pending_d = move_pending_q;
    move_left_d    = move_left_q;
    ramp_target_d  = ramp_target_q;
    ramp_origin_d  = ramp_origin_q;
    ramp_index_d   = ramp_index_q;
    speed_d        = speed_q;
    pulse_count_d  = pulse_count_q;
    switched_d     = switched_q;
    issued_d       = issued_q;
    period_d       = period_q;
    high_d         = high_q;
    low_d          = low_q;
    out_valid_d    = out_valid_q && !out_chan_o.ready;
    out_d          = out_q;
    u_req          = '0;
    u_opa          = '0;
    u_opb          = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          move_pending_d = pend_now;
          switched_d     = 1'b0;
          if (changing && (speed_q == '0)) begin
            applied_up_d  = in_chan_i.payload.want_up;
            pulse_count_d = '0;
            switched_d    = 1'b1;
          end
          if (!changing) begin
            move_pending_d = 1'b0;
            move_left_d    = left_now;
          end
          if (ramp_target_q != target_now) begin
            ramp_origin_d = speed_q;
            ramp_target_d = target_now;
            ramp_index_d  = '0;
          end
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (!idx_live) begin
          state_d = ST_SPM;
        end else if (idx_end || (ramp_span == '0)) begin
          speed_d      = idx_end ? ramp_target_q : ramp_origin_q;
          ramp_index_d = ramp_index_q + INDEX_W'(1);
          state_d      = ST_SPM;
        end else begin
          u_req.start = 1'b1;
          u_opa       = OPA_W'(ramp_span);
          u_opb       = OPB_W'(ramp_index_q[SPEED_W-1:0]);
          state_d     = ST_RAMP_MUL;
        end
      end
      ST_RAMP_MUL: begin
        if (u_rsp.done) begin
          u_req.start     = 1'b1;
          u_req.is_div    = 1'b1;
          u_req.short_div = 1'b1;
          u_opa           = u_res;
          u_opb           = OPB_W'(ramp_steps_q);
          state_d         = ST_RAMP_DIV;
        end
      end
      ST_RAMP_DIV: begin
        if (u_rsp.done) begin
          speed_d      = ramp_down ? (ramp_origin_q - ramp_part[SPEED_W-1:0])
                                   : (ramp_origin_q + ramp_part[SPEED_W-1:0]);
          ramp_index_d = ramp_index_q + INDEX_W'(1);
          state_d      = ST_SPM;
        end
      end
      ST_SPM: begin
        if (speed_q == '0) begin
          period_d = '0;
          state_d  = ST_PULSE;
        end else begin
          u_req.start = 1'b1;
          u_opa       = OPA_W'(steps_rev_q);
          u_opb       = OPB_W'(speed_q);
          state_d     = ST_SPM_WAIT;
        end
      end
      ST_SPM_WAIT: begin
        if (u_rsp.done) begin
          if (u_res == '0) begin
            period_d = '0;
            state_d  = ST_PULSE;
          end else begin
            u_req.start  = 1'b1;
            u_req.is_div = 1'b1;
            u_opa        = OPA_W'(PERIOD_NUM_US);
            u_opb        = u_res[OPB_W-1:0];
            state_d      = ST_PER_WAIT;
          end
        end
      end
      ST_PER_WAIT: begin
        if (u_rsp.done) begin
          period_d = u_res[TIME_W-1:0];
          state_d  = ST_PULSE;
        end
      end
      ST_PULSE: begin
        if ((speed_q != '0) && (period_q >= TIME_W'(min_pulse_q))) begin
          issued_d      = 1'b1;
          pulse_count_d = pulse_count_q + COUNT_W'(1);
          u_req.start   = 1'b1;
          u_opa         = OPA_W'(period_q);
          u_opb         = OPB_W'(duty_eff);
          state_d       = ST_DUTY_MUL;
        end else begin
          issued_d = 1'b0;
          high_d   = '0;
          low_d    = IDLE_WAIT_US;
          state_d  = ST_OUT;
        end
      end
      ST_DUTY_MUL: begin
        if (u_rsp.done) begin
          u_req.start  = 1'b1;
          u_req.is_div = 1'b1;
          u_opa        = u_res;
          u_opb        = OPB_W'(DUTY_FULL);
          state_d      = ST_DUTY_DIV;
        end
      end
      ST_DUTY_DIV: begin
        if (u_rsp.done) begin
          high_d  = u_res[TIME_W-1:0];
          low_d   = period_q - u_res[TIME_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_chan_o.ready) begin
          out_valid_d                = 1'b1;
          out_d.dir_level            = applied_up_q;
          out_d.dir_switched         = switched_q;
          out_d.pulse_issued         = issued_q;
          out_d.high_time_us         = high_q;
          out_d.low_time_us          = low_q;
          out_d.speed_now_rpm        = speed_q;
          out_d.steps_since_reversal = pulse_count_q;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The shared unit is only ever started when it has finished its previous operation.
  a_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_req.start |-> !u_rsp.busy)
    else $error("arithmetic unit started while busy");

  // A finished operation always follows cycles of work.
  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_rsp.done |-> $past(u_rsp.busy))
    else $error("arithmetic unit finished without working");

  // A direction change clears the step count, so its slot counts at most its own pulse.
  a_switch_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.dir_switched)
      |-> (out_q.steps_since_reversal == COUNT_W'(out_q.pulse_issued)))
    else $error("step count not cleared in a direction change slot");

endmodule

FILE: rtl/core/srpg_muldiv.sv
// Shared serial unit: shift-add multiply and restoring divide, one bit per cycle.
module srpg_muldiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srpg_pkg::srpg_req_t        req_i,
  input  logic [srpg_pkg::OPA_W-1:0] opa_i,
  input  logic [srpg_pkg::OPB_W-1:0] opb_i,
  output srpg_pkg::srpg_rsp_t        rsp_o,
  output logic [srpg_pkg::OPA_W-1:0] res_o,
  output logic [srpg_pkg::OPB_W-1:0] rem_o
);
  import srpg_pkg::*;

  srpg_unit_e       state_q, state_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OPA_W-1:0] a_q, a_d;
  logic [OPA_W-1:0] acc_q, acc_d;
  logic [OPB_W-1:0] b_q, b_d;
  logic [OPB_W-1:0] rem_q, rem_d;
  logic [OPB_W:0]   div_t;
  logic [OPB_W:0]   div_sub;
  logic             div_ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UNIT_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    // One restoring step: bring down the next dividend bit and try the divisor.
    div_t   = {rem_q, a_q[OPA_W-1]};
    div_ge  = div_t >= {1'b0, b_q};
    div_sub = div_t - {1'b0, b_q};
    case (state_q)
      UNIT_IDLE: begin
        if (req_i.start) begin
          acc_d = '0;
          b_d   = opb_i;
          if (req_i.is_div) begin
            state_d = UNIT_DIV;
            // The caller guarantees the quotient fits, so the bits above the
            // quotient length already lie below the divisor.
            if (req_i.short_div) begin
              rem_d = OPB_W'(opa_i >> SHORT_QBITS);
              a_d   = opa_i << (OPA_W - SHORT_QBITS);
              cnt_d = CNT_W'(SHORT_QBITS);
            end else begin
              rem_d = OPB_W'(opa_i >> LONG_QBITS);
              a_d   = opa_i << (OPA_W - LONG_QBITS);
              cnt_d = CNT_W'(LONG_QBITS);
            end
          end else begin
            state_d = UNIT_MUL;
            a_d     = opa_i;
          end
        end
      end
      UNIT_MUL: begin
        // Stops as soon as no multiplier bits are left.
        if (b_q == '0) begin
          state_d = UNIT_IDLE;
          done_d  = 1'b1;
        end else begin
          if (b_q[0]) begin
            acc_d = acc_q + a_q;
          end
          a_d = a_q << 1;
          b_d = b_q >> 1;
        end
      end
      UNIT_DIV: begin
        rem_d = div_ge ? div_sub[OPB_W-1:0] : div_t[OPB_W-1:0];
        acc_d = {acc_q[OPA_W-2:0], div_ge};
        a_d   = a_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = UNIT_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = UNIT_IDLE;
      end
    endcase
  end

  assign rsp_o.busy = (state_q != UNIT_IDLE);
  assign rsp_o.done = done_q;
  assign res_o      = acc_q;
  assign rem_o      = rem_q;

endmodule
